// ===== sv/glla_pkg.sv =====
// ----------------------------------------------------------------------------
// glla_pkg
// Shared types and constants for the greedy line layout and alignment block.
// ----------------------------------------------------------------------------
package glla_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_INDENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_MODE  = 2'd2;

    // reset values of the registers
    localparam logic [14:0] LINE_LENGTH_RST = 15'd640;

    // alignment codes
    localparam logic [1:0] ALIGN_LEFT    = 2'd0;
    localparam logic [1:0] ALIGN_RIGHT   = 2'd1;
    localparam logic [1:0] ALIGN_CENTER  = 2'd2;
    localparam logic [1:0] ALIGN_JUSTIFY = 2'd3;

    // item mode codes
    localparam logic [1:0] MODE_GLYPH  = 2'd0;
    localparam logic [1:0] MODE_FONT   = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    // glyph kind codes
    localparam logic [2:0] KIND_WORD  = 3'd0;
    localparam logic [2:0] KIND_SPACE = 3'd1;
    localparam logic [2:0] KIND_PRE   = 3'd2;
    localparam logic [2:0] KIND_BREAK = 3'd3;
    localparam logic [2:0] KIND_TAB   = 3'd4;

    // input queue between front and back
    localparam int QDEPTH = 2;

    // divider widths
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 10;

    // classified operation
    typedef enum logic [2:0] {
        OP_NOP,
        OP_FONT,
        OP_FINISH,
        OP_BREAK,
        OP_TAB,
        OP_GLYPH
    } glla_op_t;

    typedef struct packed {
        glla_op_t    op;
        logic        is_ws;
        logic        plain_ws;
        logic [11:0] width;
        logic [9:0]  fheight;
        logic [9:0]  fascent;
        logic [7:0]  fspace;
    } glla_item_t;

    // one placed glyph
    typedef struct packed {
        logic [15:0] num;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] ln;
        logic [15:0] tab;
        logic        ovf;
    } glla_rec_t;

    // run store entry
    typedef struct packed {
        logic [15:0] num;
        logic [15:0] x;
        logic [11:0] w;
        logic [9:0]  asc;
        logic        ws;
    } glla_run_t;

    // line store entry
    typedef struct packed {
        logic [15:0] num;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] ln;
        logic [9:0]  asc;
        logic        ws;
    } glla_line_t;

    // back end to result buffer
    typedef struct packed {
        logic      we;
        logic      start;
        glla_rec_t rec;
    } glla_ob_ctl_t;

    // saturating 16-bit add
    function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// ===== sv/glla_front.sv =====
// ----------------------------------------------------------------------------
// glla_front
// Accepts input items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module glla_front
    import glla_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [2:0]  s_glyph_kind,
    input  logic [11:0] s_glyph_width,
    input  logic [9:0]  s_font_line_height,
    input  logic [9:0]  s_font_ascent,
    input  logic [7:0]  s_font_space_width,
    output logic        q_valid,
    output glla_item_t  q_item,
    input  logic        q_pop
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    glla_item_t     q_mem [QDEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    glla_item_t     cls;
    logic           push;

    // classify the incoming item
    always_comb begin
        cls          = '0;
        cls.width    = s_glyph_width;
        cls.fheight  = s_font_line_height;
        cls.fascent  = s_font_ascent;
        cls.fspace   = s_font_space_width;
        cls.is_ws    = (s_glyph_kind == KIND_SPACE) || (s_glyph_kind == KIND_PRE);
        cls.plain_ws = (s_glyph_kind == KIND_SPACE);
        case (s_mode)
            MODE_GLYPH: begin
                case (s_glyph_kind)
                    KIND_BREAK: cls.op = OP_BREAK;
                    KIND_TAB:   cls.op = OP_TAB;
                    default:    cls.op = OP_GLYPH;
                endcase
            end
            MODE_FONT:   cls.op = OP_FONT;
            MODE_FINISH: cls.op = OP_FINISH;
            default:     cls.op = OP_NOP;
        endcase
    end

    assign s_ready = (cnt_reg != CW'(QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_item  = q_mem[rd_ptr_reg];

    // queue pointers
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== sv/glla_div.sv =====
// ----------------------------------------------------------------------------
// glla_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module glla_div
    import glla_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic              done,
    output logic [DIV_NW-1:0] quot,
    output logic [DIV_DW-1:0] rem
);

    localparam int KW = $clog2(DIV_NW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [KW-1:0]     cnt_reg, cnt_next;
    logic [DIV_NW-1:0] q_reg, q_next;
    logic [DIV_DW-1:0] r_reg, r_next;
    logic [DIV_DW-1:0] d_reg, d_next;
    logic [DIV_DW:0]   trial;

    assign trial = {r_reg, q_reg[DIV_NW-1]};

    // one shift-subtract step per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = num;
            r_next    = '0;
            d_next    = den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = DIV_DW'(trial - {1'b0, d_reg});
                q_next = {q_reg[DIV_NW-2:0], 1'b1};
            end else begin
                r_next = trial[DIV_DW-1:0];
                q_next = {q_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == KW'(DIV_NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// ===== sv/glla_engine.sv =====
// ----------------------------------------------------------------------------
// glla_engine
// Back end: run and line stores, line breaking, alignment and placement.
// ----------------------------------------------------------------------------
module glla_engine
    import glla_pkg::*;
#(
    parameter int RUN_CAP  = 32,
    parameter int LINE_CAP = 31,
    parameter int OA_W     = 6,
    parameter int OC_W     = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  q_valid,
    input  glla_item_t            q_item,
    output logic                  q_pop,
    input  logic                  ob_busy,
    output glla_ob_ctl_t          ob_ctl,
    output logic [OA_W-1:0]       ob_waddr,
    output logic [OC_W-1:0]       ob_count,
    output logic [15:0]           total_height,
    output logic [14:0]           widest_line
);

    localparam int RC_W      = $clog2(RUN_CAP + 1);
    localparam int RA_W      = $clog2(RUN_CAP);
    localparam int LC_W      = $clog2(LINE_CAP + 1);
    localparam int LA_W      = $clog2(LINE_CAP);
    localparam int SUM_W     = $clog2(RUN_CAP + LINE_CAP + 1);
    localparam int OUT_DEPTH = RUN_CAP + LINE_CAP + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FR_START,
        S_FR_RD,
        S_FR_USE,
        S_FR_END,
        S_AFTER,
        S_STORE,
        S_TAB_WAIT,
        S_TAB_EMIT,
        S_CL_START,
        S_CL_DIV,
        S_CL_RD,
        S_CL_USE,
        S_CL_END,
        S_DONE
    } state_t;

    // sequencer and pass state
    state_t            state_reg, state_next;
    glla_item_t        item_reg, item_next;
    logic [15:0]       num_reg, num_next;
    logic [RC_W-1:0]   ri_reg, ri_next;
    logic [LC_W-1:0]   li_reg, li_next;
    logic              ret_run_reg, ret_run_next;
    logic              last_reg, last_next;
    logic [15:0]       dx_reg, dx_next;
    logic              just_reg, just_next;
    logic signed [33:0] per_reg, per_next;
    logic signed [39:0] acc_reg, acc_next;
    logic              pst_reg, pst_next;
    logic              pprev_reg, pprev_next;
    logic [9:0]        tab_reg, tab_next;
    logic [OC_W-1:0]   ocnt_reg, ocnt_next;

    // store fill and gap tracking
    logic [RC_W-1:0]   rcnt_reg, rcnt_next;
    logic [LC_W-1:0]   lcnt_reg, lcnt_next;
    logic [LC_W-1:0]   gaps_reg, gaps_next;
    logic              lst_reg, lst_next;
    logic              lprev_reg, lprev_next;

    // layout state
    logic [15:0]       pen_x_reg, pen_x_next;
    logic [15:0]       pen_y_reg, pen_y_next;
    logic [15:0]       line_idx_reg, line_idx_next;
    logic [15:0]       gcount_reg, gcount_next;
    logic [15:0]       run_w_reg, run_w_next;
    logic [15:0]       line_w_reg, line_w_next;
    logic [15:0]       widest_reg, widest_next;
    logic [15:0]       hsum_reg, hsum_next;
    logic [9:0]        fh_now_reg, fh_now_next;
    logic [9:0]        lh_max_reg, lh_max_next;
    logic [9:0]        asc_now_reg, asc_now_next;
    logic [9:0]        asc_max_reg, asc_max_next;
    logic [7:0]        sp_now_reg, sp_now_next;
    logic              f_ws_reg, f_ws_next;
    logic              f_st_reg, f_st_next;
    logic              f_ls_reg, f_ls_next;
    logic              f_multi_reg, f_multi_next;

    // configuration
    logic [14:0]       line_len_reg, line_len_next;
    logic [1:0]        align_reg, align_next;

    // stores
    glla_run_t         run_mem [RUN_CAP];
    glla_line_t        line_mem [LINE_CAP];
    glla_run_t         run_rdata;
    glla_line_t        line_rdata;
    logic              run_we, run_re, line_we, line_re;
    glla_run_t         run_wdata;
    glla_line_t        line_wdata;

    // emit path
    logic              em_we;
    glla_rec_t         em_rec;
    logic              em_fit;

    // divider
    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_num, div_quot;
    logic [DIV_DW-1:0] div_den, div_rem;

    // arithmetic helpers
    logic signed [17:0] diff18;
    logic signed [17:0] center18;
    logic [17:0]        jmag18;
    logic               over_fit;
    logic [15:0]        pen_adv;
    logic               room;
    logic [9:0]         step;
    logic signed [39:0] acc_step;
    logic signed [39:0] acc_adj;
    logic [15:0]        cl_x;
    logic [15:0]        cl_y;
    logic               cl_ws_gap;
    glla_line_t         tl_ent;
    logic               tl_fit;

    glla_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    // alignment shift and fit checks
    assign diff18   = $signed({3'b0, line_len_reg}) - $signed({2'b0, line_w_reg});
    assign center18 = (diff18 + (diff18[17] ? 18'sd1 : 18'sd0)) >>> 1;
    assign jmag18   = diff18[17] ? 18'(-diff18) : 18'(diff18);
    assign over_fit = $signed({2'b0, run_w_reg})
                      > ($signed({3'b0, line_len_reg}) - $signed({2'b0, pen_x_reg}));
    assign pen_adv  = sat16(pen_x_reg, {4'b0, run_rdata.w});
    assign room     = (rcnt_reg < RC_W'(RUN_CAP))
                      && ((SUM_W'(rcnt_reg) + SUM_W'(lcnt_reg)) < SUM_W'(RUN_CAP + LINE_CAP - 1));
    assign step     = {sp_now_reg, 2'b00};
    assign tl_fit   = (lcnt_reg < LC_W'(LINE_CAP));

    // justify accumulation for the glyph being placed
    assign cl_ws_gap = just_reg && line_rdata.ws && pst_reg && !pprev_reg;
    assign acc_step  = cl_ws_gap ? acc_reg + 40'(per_reg) : acc_reg;
    assign acc_adj   = acc_step[39] ? acc_step + 40'sd65535 : acc_step;
    assign cl_x      = line_rdata.x + dx_reg + acc_adj[31:16];
    assign cl_y      = f_multi_reg
                       ? line_rdata.y + ({6'b0, asc_max_reg} - {6'b0, line_rdata.asc})
                       : line_rdata.y;

    // entry moved from run store to line store
    always_comb begin
        tl_ent     = '0;
        tl_ent.num = run_rdata.num;
        tl_ent.x   = f_ws_reg ? run_rdata.x : pen_x_reg;
        tl_ent.y   = pen_y_reg;
        tl_ent.ln  = line_idx_reg;
        tl_ent.asc = run_rdata.asc;
        tl_ent.ws  = run_rdata.ws;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        num_next      = num_reg;
        ri_next       = ri_reg;
        li_next       = li_reg;
        ret_run_next  = ret_run_reg;
        last_next     = last_reg;
        dx_next       = dx_reg;
        just_next     = just_reg;
        per_next      = per_reg;
        acc_next      = acc_reg;
        pst_next      = pst_reg;
        pprev_next    = pprev_reg;
        tab_next      = tab_reg;
        ocnt_next     = ocnt_reg;
        rcnt_next     = rcnt_reg;
        lcnt_next     = lcnt_reg;
        gaps_next     = gaps_reg;
        lst_next      = lst_reg;
        lprev_next    = lprev_reg;
        pen_x_next    = pen_x_reg;
        pen_y_next    = pen_y_reg;
        line_idx_next = line_idx_reg;
        gcount_next   = gcount_reg;
        run_w_next    = run_w_reg;
        line_w_next   = line_w_reg;
        widest_next   = widest_reg;
        hsum_next     = hsum_reg;
        fh_now_next   = fh_now_reg;
        lh_max_next   = lh_max_reg;
        asc_now_next  = asc_now_reg;
        asc_max_next  = asc_max_reg;
        sp_now_next   = sp_now_reg;
        f_ws_next     = f_ws_reg;
        f_st_next     = f_st_reg;
        f_ls_next     = f_ls_reg;
        f_multi_next  = f_multi_reg;
        line_len_next = line_len_reg;
        align_next    = align_reg;

        q_pop      = 1'b0;
        em_we      = 1'b0;
        em_rec     = '0;
        run_we     = 1'b0;
        run_re     = 1'b0;
        run_wdata  = '0;
        line_we    = 1'b0;
        line_re    = 1'b0;
        line_wdata = tl_ent;
        div_start  = 1'b0;
        div_num    = {16'h0, pen_x_reg};
        div_den    = step;
        ob_ctl     = '0;

        case (state_reg)
            // take the next item once the result buffer is drained
            S_IDLE: begin
                if (q_valid && !ob_busy) begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    ocnt_next = '0;
                    num_next  = gcount_reg;
                    case (q_item.op)
                        OP_FONT: begin
                            if (q_item.fheight != fh_now_reg) begin
                                if (lh_max_reg != '0) begin
                                    f_multi_next = 1'b1;
                                end
                                fh_now_next = q_item.fheight;
                                if (q_item.fheight > lh_max_reg) begin
                                    lh_max_next = q_item.fheight;
                                end
                            end
                            asc_now_next = q_item.fascent;
                            if (q_item.fascent > asc_max_reg) begin
                                asc_max_next = q_item.fascent;
                            end
                            sp_now_next = q_item.fspace;
                            state_next  = S_DONE;
                        end
                        OP_FINISH: begin
                            state_next = S_FR_START;
                        end
                        OP_BREAK, OP_TAB: begin
                            gcount_next = gcount_reg + 1'b1;
                            state_next  = S_FR_START;
                        end
                        OP_GLYPH: begin
                            gcount_next = gcount_reg + 1'b1;
                            state_next  = (q_item.is_ws != f_ws_reg) ? S_FR_START : S_STORE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // close the pending run; a word that overflows breaks the line
            S_FR_START: begin
                ri_next = '0;
                if (!f_ws_reg && over_fit && f_ls_reg) begin
                    ret_run_next = 1'b1;
                    last_next    = 1'b0;
                    state_next   = S_CL_START;
                end else begin
                    state_next = S_FR_RD;
                end
            end

            S_FR_RD: begin
                if (ri_reg == rcnt_reg) begin
                    state_next = S_FR_END;
                end else begin
                    run_re     = 1'b1;
                    state_next = S_FR_USE;
                end
            end

            // move one run glyph into the line store
            S_FR_USE: begin
                if (!f_ws_reg) begin
                    pen_x_next  = pen_adv;
                    line_w_next = pen_adv;
                end
                if (tl_fit) begin
                    line_we   = 1'b1;
                    lcnt_next = lcnt_reg + 1'b1;
                    if (run_rdata.ws) begin
                        if (lst_reg && !lprev_reg) begin
                            gaps_next = gaps_reg + 1'b1;
                        end
                        lprev_next = 1'b1;
                    end else begin
                        lst_next   = 1'b1;
                        lprev_next = 1'b0;
                    end
                end else begin
                    em_we      = 1'b1;
                    em_rec.num = tl_ent.num;
                    em_rec.x   = tl_ent.x;
                    em_rec.y   = pen_y_reg;
                    em_rec.ln  = line_idx_reg;
                    em_rec.ovf = 1'b1;
                end
                ri_next    = ri_reg + 1'b1;
                state_next = S_FR_RD;
            end

            S_FR_END: begin
                if (f_ws_reg) begin
                    if (f_st_reg) begin
                        pen_x_next = sat16(pen_x_reg, run_w_reg);
                    end
                end else begin
                    f_ls_next = 1'b1;
                end
                rcnt_next  = '0;
                run_w_next = '0;
                f_st_next  = 1'b1;
                state_next = S_AFTER;
            end

            // continue the item after its run is closed
            S_AFTER: begin
                case (item_reg.op)
                    OP_FINISH: begin
                        last_next  = 1'b1;
                        state_next = S_CL_START;
                    end
                    OP_BREAK: begin
                        f_ws_next    = 1'b1;
                        em_we        = 1'b1;
                        em_rec.num   = num_reg;
                        em_rec.x     = pen_x_reg;
                        em_rec.y     = pen_y_reg;
                        em_rec.ln    = line_idx_reg;
                        last_next    = 1'b0;
                        ret_run_next = 1'b0;
                        state_next   = S_CL_START;
                    end
                    OP_TAB: begin
                        f_ws_next = 1'b1;
                        if (step != '0) begin
                            div_start  = 1'b1;
                            state_next = S_TAB_WAIT;
                        end else begin
                            tab_next   = '0;
                            state_next = S_TAB_EMIT;
                        end
                    end
                    OP_GLYPH: begin
                        f_ws_next  = item_reg.is_ws;
                        state_next = S_STORE;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // keep the glyph in the run store, or report it flagged
            S_STORE: begin
                if (!room) begin
                    em_we      = 1'b1;
                    em_rec.num = num_reg;
                    em_rec.x   = pen_x_reg;
                    em_rec.y   = pen_y_reg;
                    em_rec.ln  = line_idx_reg;
                    em_rec.ovf = 1'b1;
                end else begin
                    run_we        = 1'b1;
                    run_wdata.num = num_reg;
                    run_wdata.x   = pen_x_reg;
                    run_wdata.w   = item_reg.width;
                    run_wdata.asc = asc_now_reg;
                    run_wdata.ws  = item_reg.is_ws;
                    rcnt_next     = rcnt_reg + 1'b1;
                    if (item_reg.plain_ws) begin
                        if ({4'b0, item_reg.width} > run_w_reg) begin
                            run_w_next = {4'b0, item_reg.width};
                        end
                    end else begin
                        run_w_next = sat16(run_w_reg, {4'b0, item_reg.width});
                    end
                end
                state_next = S_DONE;
            end

            S_TAB_WAIT: begin
                if (div_done) begin
                    tab_next   = step - div_rem;
                    state_next = S_TAB_EMIT;
                end
            end

            S_TAB_EMIT: begin
                em_we      = 1'b1;
                em_rec.num = num_reg;
                em_rec.x   = pen_x_reg;
                em_rec.y   = pen_y_reg;
                em_rec.ln  = line_idx_reg;
                em_rec.tab = {6'b0, tab_reg};
                pen_x_next = sat16(pen_x_reg, {6'b0, tab_reg});
                f_ls_next  = 1'b1;
                state_next = S_DONE;
            end

            // pick the alignment of the closing line
            S_CL_START: begin
                li_next    = '0;
                acc_next   = '0;
                pst_next   = 1'b0;
                pprev_next = 1'b0;
                just_next  = 1'b0;
                dx_next    = '0;
                state_next = S_CL_RD;
                case (align_reg)
                    ALIGN_RIGHT: begin
                        dx_next = diff18[15:0];
                    end
                    ALIGN_CENTER: begin
                        dx_next = center18[15:0];
                    end
                    ALIGN_JUSTIFY: begin
                        if (!last_reg && (gaps_reg > LC_W'(lprev_reg))) begin
                            div_start  = 1'b1;
                            div_num    = {jmag18[15:0], 16'h0};
                            div_den    = DIV_DW'(gaps_reg - LC_W'(lprev_reg));
                            just_next  = 1'b1;
                            state_next = S_CL_DIV;
                        end
                    end
                    default: begin
                        dx_next = '0;
                    end
                endcase
            end

            S_CL_DIV: begin
                if (div_done) begin
                    per_next   = diff18[17] ? -$signed({2'b0, div_quot})
                                            : $signed({2'b0, div_quot});
                    state_next = S_CL_RD;
                end
            end

            S_CL_RD: begin
                if (li_reg == lcnt_reg) begin
                    state_next = S_CL_END;
                end else begin
                    line_re    = 1'b1;
                    state_next = S_CL_USE;
                end
            end

            // report one glyph of the line at its final place
            S_CL_USE: begin
                if (just_reg) begin
                    acc_next = acc_step;
                    if (line_rdata.ws) begin
                        pprev_next = 1'b1;
                    end else begin
                        pst_next   = 1'b1;
                        pprev_next = 1'b0;
                    end
                end
                em_we      = 1'b1;
                em_rec.num = line_rdata.num;
                em_rec.x   = cl_x;
                em_rec.y   = cl_y;
                em_rec.ln  = line_rdata.ln;
                li_next    = li_reg + 1'b1;
                state_next = S_CL_USE == S_CL_USE ? S_CL_RD : S_CL_RD;
            end

            // empty the line store and start a new line unless finishing
            S_CL_END: begin
                f_multi_next = 1'b0;
                lcnt_next    = '0;
                gaps_next    = '0;
                lst_next     = 1'b0;
                lprev_next   = 1'b0;
                if (line_w_reg > widest_reg) begin
                    widest_next = line_w_reg;
                end
                if (last_reg) begin
                    state_next = S_DONE;
                end else begin
                    pen_x_next    = '0;
                    pen_y_next    = sat16(pen_y_reg, {6'b0, lh_max_reg});
                    line_idx_next = line_idx_reg + 1'b1;
                    hsum_next     = sat16(hsum_reg, {6'b0, lh_max_reg});
                    lh_max_next   = fh_now_reg;
                    asc_max_next  = asc_now_reg;
                    f_ls_next     = 1'b0;
                    line_w_next   = '0;
                    state_next    = ret_run_reg ? S_FR_RD : S_DONE;
                end
            end

            // hand the results to the output buffer
            S_DONE: begin
                ob_ctl.start = (ocnt_reg != '0);
                state_next   = S_IDLE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // result write, capped at the buffer depth
        em_fit       = em_we && (ocnt_reg < OC_W'(OUT_DEPTH));
        ob_ctl.we    = em_fit;
        ob_ctl.rec   = em_rec;
        if (em_fit) begin
            ocnt_next = ocnt_reg + 1'b1;
        end

        // register writes
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_LINE_LENGTH: line_len_next = cfg_wdata;
                REG_TEXT_INDENT: begin
                    if (gcount_reg == '0 && line_idx_reg == '0) begin
                        pen_x_next = {1'b0, cfg_wdata};
                    end
                end
                REG_ALIGN_MODE:  align_next = cfg_wdata[1:0];
                default:         align_next = align_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ocnt_reg     <= '0;
            rcnt_reg     <= '0;
            lcnt_reg     <= '0;
            gaps_reg     <= '0;
            lst_reg      <= 1'b0;
            lprev_reg    <= 1'b0;
            pen_x_reg    <= '0;
            pen_y_reg    <= '0;
            line_idx_reg <= '0;
            gcount_reg   <= '0;
            run_w_reg    <= '0;
            line_w_reg   <= '0;
            widest_reg   <= '0;
            hsum_reg     <= '0;
            fh_now_reg   <= '0;
            lh_max_reg   <= '0;
            asc_now_reg  <= '0;
            asc_max_reg  <= '0;
            sp_now_reg   <= '0;
            f_ws_reg     <= 1'b1;
            f_st_reg     <= 1'b0;
            f_ls_reg     <= 1'b0;
            f_multi_reg  <= 1'b0;
            line_len_reg <= LINE_LENGTH_RST;
            align_reg    <= ALIGN_LEFT;
        end else begin
            state_reg    <= state_next;
            ocnt_reg     <= ocnt_next;
            rcnt_reg     <= rcnt_next;
            lcnt_reg     <= lcnt_next;
            gaps_reg     <= gaps_next;
            lst_reg      <= lst_next;
            lprev_reg    <= lprev_next;
            pen_x_reg    <= pen_x_next;
            pen_y_reg    <= pen_y_next;
            line_idx_reg <= line_idx_next;
            gcount_reg   <= gcount_next;
            run_w_reg    <= run_w_next;
            line_w_reg   <= line_w_next;
            widest_reg   <= widest_next;
            hsum_reg     <= hsum_next;
            fh_now_reg   <= fh_now_next;
            lh_max_reg   <= lh_max_next;
            asc_now_reg  <= asc_now_next;
            asc_max_reg  <= asc_max_next;
            sp_now_reg   <= sp_now_next;
            f_ws_reg     <= f_ws_next;
            f_st_reg     <= f_st_next;
            f_ls_reg     <= f_ls_next;
            f_multi_reg  <= f_multi_next;
            line_len_reg <= line_len_next;
            align_reg    <= align_next;
        end
        item_reg    <= item_next;
        num_reg     <= num_next;
        ri_reg      <= ri_next;
        li_reg      <= li_next;
        ret_run_reg <= ret_run_next;
        last_reg    <= last_next;
        dx_reg      <= dx_next;
        just_reg    <= just_next;
        per_reg     <= per_next;
        acc_reg     <= acc_next;
        pst_reg     <= pst_next;
        pprev_reg   <= pprev_next;
        tab_reg     <= tab_next;
    end

    // run store
    always_ff @(posedge aclk) begin
        if (run_we) begin
            run_mem[rcnt_reg[RA_W-1:0]] <= run_wdata;
        end
        if (run_re) begin
            run_rdata <= run_mem[ri_reg[RA_W-1:0]];
        end
    end

    // line store
    always_ff @(posedge aclk) begin
        if (line_we) begin
            line_mem[lcnt_reg[LA_W-1:0]] <= line_wdata;
        end
        if (line_re) begin
            line_rdata <= line_mem[li_reg[LA_W-1:0]];
        end
    end

    assign ob_waddr     = ocnt_reg[OA_W-1:0];
    assign ob_count     = ocnt_reg;
    assign total_height = sat16(hsum_reg, {6'b0, lh_max_reg});
    assign widest_line  = widest_reg[15] ? 15'h7FFF : widest_reg[14:0];

endmodule

// ===== sv/glla_obuf.sv =====
// ----------------------------------------------------------------------------
// glla_obuf
// Result buffer: collects the results of one item and plays them out.
// ----------------------------------------------------------------------------
module glla_obuf
    import glla_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int OA_W  = 6,
    parameter int OC_W  = 7
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  glla_ob_ctl_t    ob_ctl,
    input  logic [OA_W-1:0] ob_waddr,
    input  logic [OC_W-1:0] ob_count,
    input  logic [15:0]     total_height,
    input  logic [14:0]     widest_line,
    output logic            ob_busy,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [15:0]     m_glyph_number,
    output logic [15:0]     m_pos_x,
    output logic [15:0]     m_pos_y,
    output logic [15:0]     m_line_number,
    output logic [15:0]     m_tab_width,
    output logic            m_overflow,
    output logic [15:0]     m_total_height,
    output logic [14:0]     m_widest_line,
    output logic            m_last
);

    typedef enum logic [1:0] {
        O_IDLE,
        O_READ,
        O_SHOW
    } ostate_t;

    ostate_t         state_reg, state_next;
    logic [OC_W-1:0] rd_reg, rd_next;
    logic [OC_W-1:0] cnt_reg, cnt_next;
    logic            rd_en;
    logic            at_last;
    glla_rec_t       mem [DEPTH];
    glla_rec_t       rdata;

    assign at_last = ((rd_reg + 1'b1) == cnt_reg);

    // play-out sequencer
    always_comb begin
        state_next = state_reg;
        rd_next    = rd_reg;
        cnt_next   = cnt_reg;
        rd_en      = 1'b0;
        case (state_reg)
            O_IDLE: begin
                if (ob_ctl.start) begin
                    cnt_next   = ob_count;
                    rd_next    = '0;
                    state_next = O_READ;
                end
            end
            O_READ: begin
                rd_en      = 1'b1;
                state_next = O_SHOW;
            end
            O_SHOW: begin
                if (m_ready) begin
                    if (at_last) begin
                        state_next = O_IDLE;
                    end else begin
                        rd_next    = rd_reg + 1'b1;
                        state_next = O_READ;
                    end
                end
            end
            default: begin
                state_next = O_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= O_IDLE;
            rd_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rd_reg    <= rd_next;
            cnt_reg   <= cnt_next;
        end
    end

    // result memory
    always_ff @(posedge aclk) begin
        if (ob_ctl.we) begin
            mem[ob_waddr] <= ob_ctl.rec;
        end
        if (rd_en) begin
            rdata <= mem[rd_reg[OA_W-1:0]];
        end
    end

    assign ob_busy        = (state_reg != O_IDLE);
    assign m_valid        = (state_reg == O_SHOW);
    assign m_glyph_number = rdata.num;
    assign m_pos_x        = rdata.x;
    assign m_pos_y        = rdata.y;
    assign m_line_number  = rdata.ln;
    assign m_tab_width    = rdata.tab;
    assign m_overflow     = rdata.ovf;
    assign m_total_height = total_height;
    assign m_widest_line  = widest_line;
    assign m_last         = at_last;

endmodule

// ===== sv/greedy_line_layout_align.sv =====
// ----------------------------------------------------------------------------
// greedy_line_layout_align
// Greedy word wrap with tab stops, mixed font heights and line alignment.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    mode, glyph kind/width, font fields
//   m_       out        m_valid/m_ready    placed glyph, totals, last
//   cfg_     in         cfg_wr_en          cfg_index, cfg_wdata
//
// One item at a time in the back end: a glyph that joins its run is stored;
// when a run closes, its glyphs move from the run store into the line store,
// and when a line ends, each glyph of the closing line is reported; a tab or
// a justified line also waits on the shared bit-serial divider. Results are
// read and shown one by one from the result buffer before the next item starts.
// Reset is synchronous and active low; the stores need no clearing pass.
// The input queue holds two items so the source can run ahead of the back end.
// ----------------------------------------------------------------------------
module greedy_line_layout_align
    import glla_pkg::*;
#(
    parameter int RUN_CAP  = 32,
    parameter int LINE_CAP = 31
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [2:0]            s_glyph_kind,
    input  logic [11:0]           s_glyph_width,
    input  logic [9:0]            s_font_line_height,
    input  logic [9:0]            s_font_ascent,
    input  logic [7:0]            s_font_space_width,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [15:0]           m_glyph_number,
    output logic signed [15:0]    m_pos_x,
    output logic [15:0]           m_pos_y,
    output logic [15:0]           m_line_number,
    output logic [15:0]           m_tab_width,
    output logic                  m_overflow,
    output logic [15:0]           m_total_height,
    output logic [14:0]           m_widest_line,
    output logic                  m_last,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int OUT_DEPTH = RUN_CAP + LINE_CAP + 1;
    localparam int OA_W      = $clog2(OUT_DEPTH);
    localparam int OC_W      = $clog2(OUT_DEPTH + 1);

    logic            q_valid, q_pop;
    glla_item_t      q_item;
    logic            ob_busy;
    glla_ob_ctl_t    ob_ctl;
    logic [OA_W-1:0] ob_waddr;
    logic [OC_W-1:0] ob_count;
    logic [15:0]     total_height;
    logic [14:0]     widest_line;
    logic [15:0]     pos_x_bits;

    // front end: accept and classify
    glla_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_glyph_kind       (s_glyph_kind),
        .s_glyph_width      (s_glyph_width),
        .s_font_line_height (s_font_line_height),
        .s_font_ascent      (s_font_ascent),
        .s_font_space_width (s_font_space_width),
        .q_valid            (q_valid),
        .q_item             (q_item),
        .q_pop              (q_pop)
    );

    // back end: layout and alignment
    glla_engine #(
        .RUN_CAP  (RUN_CAP),
        .LINE_CAP (LINE_CAP),
        .OA_W     (OA_W),
        .OC_W     (OC_W)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .ob_busy      (ob_busy),
        .ob_ctl       (ob_ctl),
        .ob_waddr     (ob_waddr),
        .ob_count     (ob_count),
        .total_height (total_height),
        .widest_line  (widest_line)
    );

    // result buffer
    glla_obuf #(
        .DEPTH (OUT_DEPTH),
        .OA_W  (OA_W),
        .OC_W  (OC_W)
    ) u_obuf (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ob_ctl         (ob_ctl),
        .ob_waddr       (ob_waddr),
        .ob_count       (ob_count),
        .total_height   (total_height),
        .widest_line    (widest_line),
        .ob_busy        (ob_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_glyph_number (m_glyph_number),
        .m_pos_x        (pos_x_bits),
        .m_pos_y        (m_pos_y),
        .m_line_number  (m_line_number),
        .m_tab_width    (m_tab_width),
        .m_overflow     (m_overflow),
        .m_total_height (m_total_height),
        .m_widest_line  (m_widest_line),
        .m_last         (m_last)
    );

    assign m_pos_x = $signed(pos_x_bits);

    // back end never takes an item while results are still playing out
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !ob_busy)
        else $error("item taken while result buffer busy");

    // results are shown only while the buffer is active
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> ob_busy)
        else $error("result shown from idle buffer");

    // nothing follows the last result of an item in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> !m_valid)
        else $error("result shown after last");

    // no result is written while the buffer plays out
    assert property (@(posedge aclk) disable iff (!aresetn) ob_ctl.we |-> !ob_busy)
        else $error("result written during play-out");

endmodule
